@@ rtl/arm2_alu_immediate_and_branch_top_macros.svh @@
// -----------------------------------------------------------------------------
// arm2 assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef ARM2_ALU_IMMEDIATE_AND_BRANCH_TOP_MACROS_SVH
`define ARM2_ALU_IMMEDIATE_AND_BRANCH_TOP_MACROS_SVH

// same-cycle implication
`define ARM2_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARM2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/arm2_pkg.sv @@
// -----------------------------------------------------------------------------
// arm2_pkg
// Shared types and constants for the ARM2 immediate ALU and branch unit.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arm2_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned NREGS   = 16;
  localparam int unsigned RIDX_W  = 4;

  localparam logic [RIDX_W-1:0] REG_LR = 4'd14;
  localparam logic [RIDX_W-1:0] REG_PC = 4'd15;

  localparam logic [3:0] GRP_ALU_IMM = 4'd2;
  localparam logic [3:0] GRP_B       = 4'd10;
  localparam logic [3:0] GRP_BL      = 4'd11;

  localparam logic [XLEN-1:0] LINK_STEP = 32'd4;

  typedef enum logic [1:0] {
    KIND_ALU = 2'd0,
    KIND_B   = 2'd1,
    KIND_BL  = 2'd2,
    KIND_NOP = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_AND = 3'd0,
    OP_EOR = 3'd1,
    OP_SUB = 3'd2,
    OP_RSB = 3'd3,
    OP_ADD = 3'd4,
    OP_ADC = 3'd5,
    OP_SBC = 3'd6,
    OP_RSC = 3'd7
  } alu_op_e;

  // NZCV bit positions
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  typedef struct packed {
    alu_op_e    op;
    logic       set_flags;
    logic [7:0] imm8;
    logic [3:0] rot;
  } alu_req_t;

endpackage

@@ rtl/arm2_ram.sv @@
// -----------------------------------------------------------------------------
// arm2_ram
// Generic single-write, single-read RAM with registered read (read-first).
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm2_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/arm2_alu.sv @@
// -----------------------------------------------------------------------------
// arm2_alu
// Immediate operand rotator, adder/logic unit and NZCV flag update.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm2_alu (
  input  arm2_pkg::alu_req_t       req_i,
  input  logic [arm2_pkg::XLEN-1:0] opa_i,
  input  logic [3:0]               flags_i,
  output logic [arm2_pkg::XLEN-1:0] result_o,
  output logic [3:0]               flags_o
);

  logic [2*arm2_pkg::XLEN-1:0] rot_dbl;
  logic [arm2_pkg::XLEN-1:0]   imm;
  logic [arm2_pkg::XLEN-1:0]   x;
  logic [arm2_pkg::XLEN-1:0]   y;
  logic                        cin;
  logic [arm2_pkg::XLEN:0]     sum;
  logic                        logical;
  logic                        ovf;
  logic [arm2_pkg::XLEN-1:0]   res;

  always_comb begin
    // rotate right by twice rot: shift a doubled word
    rot_dbl = {24'd0, req_i.imm8, 24'd0, req_i.imm8} >> {req_i.rot, 1'b0};
    imm     = rot_dbl[arm2_pkg::XLEN-1:0];

    logical = 1'b0;
    x       = opa_i;
    y       = imm;
    cin     = 1'b0;
    case (req_i.op)
      arm2_pkg::OP_AND: logical = 1'b1;
      arm2_pkg::OP_EOR: logical = 1'b1;
      arm2_pkg::OP_SUB: begin y = ~imm; cin = 1'b1; end
      arm2_pkg::OP_RSB: begin x = imm; y = ~opa_i; cin = 1'b1; end
      arm2_pkg::OP_ADD: cin = 1'b0;
      arm2_pkg::OP_ADC: cin = flags_i[arm2_pkg::FLAG_C];
      arm2_pkg::OP_SBC: begin y = ~imm; cin = flags_i[arm2_pkg::FLAG_C]; end
      arm2_pkg::OP_RSC: begin x = imm; y = ~opa_i; cin = flags_i[arm2_pkg::FLAG_C]; end
      default: logical = 1'b0;
    endcase

    sum = {1'b0, x} + {1'b0, y} + {{arm2_pkg::XLEN{1'b0}}, cin};
    ovf = ~(x[arm2_pkg::XLEN-1] ^ y[arm2_pkg::XLEN-1])
          & (x[arm2_pkg::XLEN-1] ^ sum[arm2_pkg::XLEN-1]);

    if (req_i.op == arm2_pkg::OP_AND) begin
      res = opa_i & imm;
    end else if (req_i.op == arm2_pkg::OP_EOR) begin
      res = opa_i ^ imm;
    end else begin
      res = sum[arm2_pkg::XLEN-1:0];
    end

    flags_o = flags_i;
    if (req_i.set_flags) begin
      flags_o[arm2_pkg::FLAG_N] = res[arm2_pkg::XLEN-1];
      flags_o[arm2_pkg::FLAG_Z] = (res == '0);
      if (!logical) begin
        flags_o[arm2_pkg::FLAG_C] = sum[arm2_pkg::XLEN];
        flags_o[arm2_pkg::FLAG_V] = ovf;
      end
    end
    result_o = res;
  end

endmodule

@@ rtl/arm2_alu_immediate_and_branch_top.sv @@
// -----------------------------------------------------------------------------
// arm2_alu_immediate_and_branch_top
// An accepted instruction is registered along with its RAM read, then executes into
// the output register.
// Throughput: one instruction per cycle unless out_ready_i stalls the output; set by the
// single register file RAM read port, with the previous cycle's write forwarded to the next read.
// Reset: registers, flags and PC read as zero; no clearing pass is needed.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm2_alu_immediate_and_branch_top_macros.svh"

module arm2_alu_immediate_and_branch_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        dest_write_o,
  output logic [3:0]  dest_index_o,
  output logic [31:0] dest_value_o,
  output logic [3:0]  flags_out_o,
  output logic [31:0] pc_value_o
);

  localparam int unsigned W  = arm2_pkg::XLEN;
  localparam int unsigned RW = arm2_pkg::RIDX_W;

  // execute stage
  logic          s1_valid_q, s1_valid_d;
  logic [31:0]   s1_instr_q;
  logic          s1_adv;
  logic          in_fire;

  // architectural state held in flops
  logic [3:0]    flags_q, flags_d;
  logic [W-1:0]  pc_q, pc_d;
  logic [arm2_pkg::NREGS-1:0] rvalid_q;

  // last write, for forwarding
  logic          fwd_we_q;
  logic [RW-1:0] fwd_wa_q;
  logic [W-1:0]  fwd_wd_q;

  // RAM ports
  logic          ram_we;
  logic [RW-1:0] ram_wa;
  logic [W-1:0]  ram_wd;
  logic [RW-1:0] ram_ra;
  logic [W-1:0]  ram_rd;

  // output register
  logic          out_valid_q;
  arm2_pkg::kind_e kind_q, kind_d;
  logic          dw_q, dw_d;
  logic [RW-1:0] di_q, di_d;
  logic [W-1:0]  dv_q, dv_d;
  logic [3:0]    fo_q;
  logic [W-1:0]  pco_q;

  // decode and execute
  logic [3:0]    group;
  logic [RW-1:0] rn, rd;
  logic [W-1:0]  opa;
  logic [W-1:0]  rf_val;
  logic [W-1:0]  alu_res;
  logic [3:0]    alu_flags;
  logic [W-1:0]  br_off;
  arm2_pkg::alu_req_t alu_req;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_adv);

  // re-read the held operand while stalled so the RAM output stays current
  assign ram_ra = in_fire ? instr_i[19:16] : s1_instr_q[19:16];

  arm2_ram #(
    .Width(W),
    .Depth(arm2_pkg::NREGS)
  ) u_rf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  assign group = s1_instr_q[27:24];
  assign rn    = s1_instr_q[19:16];
  assign rd    = s1_instr_q[15:12];

  always_comb begin
    if (fwd_we_q && (fwd_wa_q == rn)) begin
      rf_val = fwd_wd_q;
    end else if (rvalid_q[rn]) begin
      rf_val = ram_rd;
    end else begin
      rf_val = '0;
    end
    opa = (rn == arm2_pkg::REG_PC) ? pc_q : rf_val;
  end

  assign alu_req.op        = arm2_pkg::alu_op_e'(s1_instr_q[23:21]);
  assign alu_req.set_flags = s1_instr_q[20];
  assign alu_req.imm8      = s1_instr_q[7:0];
  assign alu_req.rot       = s1_instr_q[11:8];

  arm2_alu u_alu (
    .req_i   (alu_req),
    .opa_i   (opa),
    .flags_i (flags_q),
    .result_o(alu_res),
    .flags_o (alu_flags)
  );

  assign br_off = {{6{s1_instr_q[23]}}, s1_instr_q[23:0], 2'b00};

  always_comb begin
    kind_d  = arm2_pkg::KIND_NOP;
    dw_d    = 1'b0;
    di_d    = '0;
    dv_d    = '0;
    flags_d = flags_q;
    pc_d    = pc_q;
    case (group)
      arm2_pkg::GRP_ALU_IMM: begin
        kind_d  = arm2_pkg::KIND_ALU;
        dw_d    = 1'b1;
        di_d    = rd;
        dv_d    = alu_res;
        flags_d = alu_flags;
        if (rd == arm2_pkg::REG_PC) begin
          pc_d = alu_res;
        end
      end
      arm2_pkg::GRP_B: begin
        kind_d = arm2_pkg::KIND_B;
        pc_d   = pc_q + br_off;
      end
      arm2_pkg::GRP_BL: begin
        kind_d = arm2_pkg::KIND_BL;
        dw_d   = 1'b1;
        di_d   = arm2_pkg::REG_LR;
        dv_d   = pc_q + arm2_pkg::LINK_STEP;
        pc_d   = pc_q + br_off;
      end
      default: kind_d = arm2_pkg::KIND_NOP;
    endcase
  end

  assign ram_we = s1_adv && dw_d;
  assign ram_wa = di_d;
  assign ram_wd = dv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      pc_q        <= '0;
      rvalid_q    <= '0;
      fwd_we_q    <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      fwd_we_q   <= ram_we;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
        pc_q        <= pc_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        rvalid_q[ram_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_instr_q <= instr_i;
    end
    fwd_wa_q <= ram_wa;
    fwd_wd_q <= ram_wd;
    if (s1_adv) begin
      kind_q <= kind_d;
      dw_q   <= dw_d;
      di_q   <= di_d;
      dv_q   <= dv_d;
      fo_q   <= flags_d;
      pco_q  <= pc_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign dest_write_o = dw_q;
  assign dest_index_o = di_q;
  assign dest_value_o = dv_q;
  assign flags_out_o  = fo_q;
  assign pc_value_o   = pco_q;

  `ARM2_ASSERT_SAME(a_we_only_on_adv, ram_we, s1_valid_q && s1_adv, "rf write without execute")
  `ARM2_ASSERT_NEXT(a_stall_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_instr_q), "stalled instruction lost")
  `ARM2_ASSERT_SAME(a_nop_no_write, out_valid_q && (kind_q == arm2_pkg::KIND_NOP), !dw_q, "no-op wrote a register")
  `ARM2_ASSERT_NEXT(a_pc_tracks_out, s1_adv, pco_q == pc_q, "pc output differs from pc state")

endmodule
